FILE: design/cd_pkg.sv
// ----------------------------------------------------------------------------
// cd_pkg: shared definitions for the circular deque
// Depth, field widths, operation and status codes, and the per-cell control.
// ----------------------------------------------------------------------------
package cd_pkg;

    // Number of words the deque holds.
    localparam int DEPTH = 4;

    // Widths derived from the depth.
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    // Operation codes carried by the opcode field.
    typedef enum logic [1:0] {
        OP_PUSH_REAR  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } opcode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Control for one storage cell in a given cycle.
    typedef struct packed {
        logic load;       // capture the pushed word
        logic take_prev;  // capture the neighbor toward the front
        logic take_next;  // capture the neighbor toward the rear
    } cell_ctl_t;

endpackage

FILE: design/cd_cell.sv
// ----------------------------------------------------------------------------
// cd_cell: one word of the deque
// Holds one slot and, on command, loads the pushed word or shifts in the
// word of either neighbor.
// ----------------------------------------------------------------------------
module cd_cell (
    input  logic                                    clk,
    input  cd_pkg::cell_ctl_t                       ctl,
    input  logic signed [cd_pkg::WORD_W-1:0]        prev_data,
    input  logic signed [cd_pkg::WORD_W-1:0]        next_data,
    input  logic signed [cd_pkg::WORD_W-1:0]        load_data,
    output logic signed [cd_pkg::WORD_W-1:0]        data
);

    logic signed [cd_pkg::WORD_W-1:0] data_reg;
    logic signed [cd_pkg::WORD_W-1:0] data_next;

    // Select what this cell holds next cycle.
    always_comb
    begin
        data_next = data_reg;
        if (ctl.load)
        begin
            data_next = load_data;
        end
        else if (ctl.take_prev)
        begin
            data_next = prev_data;
        end
        else if (ctl.take_next)
        begin
            data_next = next_data;
        end
    end

    // Word storage needs no reset: the count guards every read.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: design/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue built as a row of shifting word cells
// Result: a beat taken at a clock edge is registered there and shows its result, with done high, in the cycle after.
// Throughput: one operation per cycle; busy stays low, the update is one cell-row step.
// Reset: the count and the done strobe clear at once; word cells are not cleared.
// ----------------------------------------------------------------------------
module circular_deque (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [1:0]                              opcode,
    input  logic signed [cd_pkg::WORD_W-1:0]        value,
    output logic                                    done,
    output logic [1:0]                              status,
    output logic signed [cd_pkg::WORD_W-1:0]        removed_value,
    output logic [cd_pkg::CNT_W-1:0]                occupancy
);

    // The front word lives in cell 0; words fill toward higher cells.
    logic signed [cd_pkg::WORD_W-1:0] cell_data [cd_pkg::DEPTH];
    cd_pkg::cell_ctl_t                cell_ctl  [cd_pkg::DEPTH];

    logic [cd_pkg::CNT_W-1:0]         count_reg;
    logic [cd_pkg::CNT_W-1:0]         count_next;
    logic                             done_reg;
    logic [1:0]                       status_reg;
    logic [1:0]                       status_next;
    logic signed [cd_pkg::WORD_W-1:0] removed_reg;
    logic signed [cd_pkg::WORD_W-1:0] removed_next;
    logic [cd_pkg::CNT_W-1:0]         occupancy_reg;

    logic                             accept;
    logic                             full;
    logic                             empty;
    logic                             do_push_rear;
    logic                             do_push_front;
    logic                             do_pop_front;
    logic                             do_pop_rear;
    logic [cd_pkg::IDX_W-1:0]         rear_idx;
    logic [cd_pkg::CNT_W-1:0]         count_dec;

    // Every beat completes in the cycle it is taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign full  = (count_reg == cd_pkg::CNT_W'(cd_pkg::DEPTH));
    assign empty = (count_reg == '0);

    // Decode the operation against the fill level.
    always_comb
    begin
        do_push_rear  = 1'b0;
        do_push_front = 1'b0;
        do_pop_front  = 1'b0;
        do_pop_rear   = 1'b0;
        status_next   = cd_pkg::ST_DONE;
        if (accept)
        begin
            unique case (opcode)
                cd_pkg::OP_PUSH_REAR:
                begin
                    do_push_rear = !full;
                    status_next  = full ? cd_pkg::ST_FULL : cd_pkg::ST_DONE;
                end
                cd_pkg::OP_PUSH_FRONT:
                begin
                    do_push_front = !full;
                    status_next   = full ? cd_pkg::ST_FULL : cd_pkg::ST_DONE;
                end
                cd_pkg::OP_POP_FRONT:
                begin
                    do_pop_front = !empty;
                    status_next  = empty ? cd_pkg::ST_EMPTY : cd_pkg::ST_DONE;
                end
                cd_pkg::OP_POP_REAR:
                begin
                    do_pop_rear = !empty;
                    status_next = empty ? cd_pkg::ST_EMPTY : cd_pkg::ST_DONE;
                end
                default:
                begin
                    status_next = cd_pkg::ST_DONE;
                end
            endcase
        end
    end

    // The rear word sits one below the count.
    assign count_dec = count_reg - cd_pkg::CNT_W'(1);
    assign rear_idx  = count_dec[cd_pkg::IDX_W-1:0];

    // Word handed back by a successful pop.
    always_comb
    begin
        removed_next = '0;
        if (do_pop_front)
        begin
            removed_next = cell_data[0];
        end
        else if (do_pop_rear)
        begin
            removed_next = cell_data[rear_idx];
        end
    end

    // Fill level after this beat.
    always_comb
    begin
        count_next = count_reg;
        if (do_push_rear || do_push_front)
        begin
            count_next = count_reg + cd_pkg::CNT_W'(1);
        end
        else if (do_pop_front || do_pop_rear)
        begin
            count_next = count_dec;
        end
    end

    // Row of cells: push front shifts toward the rear, pop front toward the front.
    for (genvar i = 0; i < cd_pkg::DEPTH; i++)
    begin : g_cell
        logic signed [cd_pkg::WORD_W-1:0] prev_word;
        logic signed [cd_pkg::WORD_W-1:0] next_word;

        if (i == 0)
        begin : g_first
            assign prev_word = value;
        end
        else
        begin : g_mid
            assign prev_word = cell_data[i-1];
        end

        if (i == cd_pkg::DEPTH - 1)
        begin : g_last
            assign next_word = cell_data[i];
        end
        else
        begin : g_inner
            assign next_word = cell_data[i+1];
        end

        assign cell_ctl[i].load      = do_push_rear && (count_reg == cd_pkg::CNT_W'(i));
        assign cell_ctl[i].take_prev = do_push_front;
        assign cell_ctl[i].take_next = do_pop_front;

        cd_cell u_cell (
            .clk       (clk),
            .ctl       (cell_ctl[i]),
            .prev_data (prev_word),
            .next_data (next_word),
            .load_data (value),
            .data      (cell_data[i])
        );
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Result beat registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            removed_reg   <= removed_next;
            occupancy_reg <= count_next;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign occupancy     = occupancy_reg;

endmodule
